[src/yuvrgb_pkg.sv]
package yuvrgb_pkg;

	typedef struct packed {
		logic [7:0] luma_in;
		logic [7:0] cb_in;
		logic [7:0] cr_in;
	} yuv_pix_t;

	typedef struct packed {
		logic [7:0] red_out;
		logic [7:0] green_out;
		logic [7:0] blue_out;
	} rgb_pix_t;

	typedef enum logic [3:0] {
		REG_LUMA_SCALE    = 4'd0,
		REG_LUMA_OFFSET   = 4'd1,
		REG_LUMA_INVERT   = 4'd2,
		REG_U_SCALE       = 4'd3,
		REG_V_SCALE       = 4'd4,
		REG_CHROMA_OFFSET = 4'd5,
		REG_CHROMA_INVERT = 4'd6,
		REG_MATRIX_SELECT = 4'd7
	} cfg_reg_t;

	localparam logic [7:0] RST_LUMA_SCALE    = 8'd1;
	localparam logic [7:0] RST_LUMA_OFFSET   = 8'd125;
	localparam logic [7:0] RST_U_SCALE       = 8'd1;
	localparam logic [7:0] RST_V_SCALE       = 8'd1;
	localparam logic [7:0] RST_CHROMA_OFFSET = 8'd128;

	localparam logic [7:0] CHROMA_ZERO = 8'd128;
	localparam logic signed [8:0] LUMA_BLACK = 9'sd16;

	// Q16 matrix coefficients.
	localparam logic signed [18:0] COEF_Y      = 19'sd76309;
	localparam logic signed [18:0] COEF_RV_601 = 19'sd104597;
	localparam logic signed [18:0] COEF_GU_601 = -19'sd25675;
	localparam logic signed [18:0] COEF_GV_601 = -19'sd53279;
	localparam logic signed [18:0] COEF_BU_601 = 19'sd132201;
	localparam logic signed [18:0] COEF_RV_709 = 19'sd117489;
	localparam logic signed [18:0] COEF_GU_709 = -19'sd13975;
	localparam logic signed [18:0] COEF_GV_709 = -19'sd34925;
	localparam logic signed [18:0] COEF_BU_709 = 19'sd138438;

	function automatic logic [7:0] clamp_u8(input logic signed [29:0] v);
		logic [7:0] r;
		if (v < 30'sd0) begin
			r = 8'd0;
		end else if (v > 30'sd255) begin
			r = 8'd255;
		end else begin
			r = v[7:0];
		end
		return r;
	endfunction

endpackage

[src/yuv_adjust_and_rgb_convert_top.sv]
// Five register stages (s1 to s5); one pixel per clock while rgb_ready does not stall them.
// Pivot, gain, clamp, matrix products and sums take a stage each.
// Back-pressure on rgb_ready stalls all stages together; nothing is dropped or repeated.
// Reset (arst_n low, asynchronous) empties the pipeline and loads the register
// defaults: gains of 1, luma pivot 125, chroma pivot 128, no inversion, BT.601.
module yuv_adjust_and_rgb_convert_top
	import yuvrgb_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       pix_valid,
	output logic       pix_ready,
	input  yuv_pix_t   pix,
	output logic       rgb_valid,
	input  logic       rgb_ready,
	output rgb_pix_t   rgb,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [3:0] cfg_index,
	input  logic [7:0] cfg_data
);

	logic [7:0] luma_scale_q, luma_offset_q, u_scale_q, v_scale_q, chroma_offset_q;
	logic       luma_invert_q, chroma_invert_q, matrix_select_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			luma_scale_q    <= RST_LUMA_SCALE;
			luma_offset_q   <= RST_LUMA_OFFSET;
			luma_invert_q   <= 1'b0;
			u_scale_q       <= RST_U_SCALE;
			v_scale_q       <= RST_V_SCALE;
			chroma_offset_q <= RST_CHROMA_OFFSET;
			chroma_invert_q <= 1'b0;
			matrix_select_q <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_LUMA_SCALE:    luma_scale_q    <= cfg_data;
				REG_LUMA_OFFSET:   luma_offset_q   <= cfg_data;
				REG_LUMA_INVERT:   luma_invert_q   <= cfg_data[0];
				REG_U_SCALE:       u_scale_q       <= cfg_data;
				REG_V_SCALE:       v_scale_q       <= cfg_data;
				REG_CHROMA_OFFSET: chroma_offset_q <= cfg_data;
				REG_CHROMA_INVERT: chroma_invert_q <= cfg_data[0];
				REG_MATRIX_SELECT: matrix_select_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Display mode. The user must change configuration only while the pipeline is empty (the
	// block does not enforce this), so every stage may read these decodes directly.
	logic ls, us, vs, luma_only, u_only, v_only, force_gray;
	logic [7:0] y_off, y_scl;
	logic       y_inv;

	always_comb begin
		ls         = |luma_scale_q;
		us         = |u_scale_q;
		vs         = |v_scale_q;
		luma_only  = ls && !us && !vs;
		u_only     = !ls && us && !vs;
		v_only     = !ls && !us && vs;
		force_gray = luma_only || u_only || v_only;
		if (u_only) begin
			y_off = chroma_offset_q;
			y_scl = u_scale_q;
			y_inv = chroma_invert_q;
		end else if (v_only) begin
			y_off = chroma_offset_q;
			y_scl = v_scale_q;
			y_inv = chroma_invert_q;
		end else begin
			y_off = luma_offset_q;
			y_scl = luma_scale_q;
			y_inv = luma_invert_q;
		end
	end

	logic adv;
	assign adv       = !rgb_valid || rgb_ready;
	assign pix_ready = adv;

	// Stage 1: plane select for the gray modes, optional inversion and removal of the pivot.
	logic [7:0] y_smp, y_pre, u_pre, v_pre;
	logic signed [8:0] yd_s1, ud_s1, vd_s1;
	logic vld_s1;

	always_comb begin
		if (u_only) begin
			y_smp = pix.cb_in;
		end else if (v_only) begin
			y_smp = pix.cr_in;
		end else begin
			y_smp = pix.luma_in;
		end
		y_pre = y_inv ? ~y_smp : y_smp;
		u_pre = chroma_invert_q ? ~pix.cb_in : pix.cb_in;
		v_pre = chroma_invert_q ? ~pix.cr_in : pix.cr_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= pix_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			yd_s1 <= $signed({1'b0, y_pre}) - $signed({1'b0, y_off});
			ud_s1 <= $signed({1'b0, u_pre}) - $signed({1'b0, chroma_offset_q});
			vd_s1 <= $signed({1'b0, v_pre}) - $signed({1'b0, chroma_offset_q});
		end
	end

	// Stage 2: gain multiply.
	logic signed [17:0] yp_s2, up_s2, vp_s2;
	logic vld_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			yp_s2 <= 18'(yd_s1) * 18'($signed({1'b0, y_scl}));
			up_s2 <= 18'(ud_s1) * 18'($signed({1'b0, u_scale_q}));
			vp_s2 <= 18'(vd_s1) * 18'($signed({1'b0, v_scale_q}));
		end
	end

	// Stage 3: add the pivot back and clamp; gray modes force chroma to zero.
	logic signed [29:0] ysum, usum, vsum;
	logic [7:0] y_s3, u_s3, v_s3;
	logic vld_s3;

	always_comb begin
		ysum = 30'(yp_s2) + $signed({22'd0, y_off});
		usum = 30'(up_s2) + $signed({22'd0, chroma_offset_q});
		vsum = 30'(vp_s2) + $signed({22'd0, chroma_offset_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			y_s3 <= clamp_u8(ysum);
			u_s3 <= force_gray ? CHROMA_ZERO : clamp_u8(usum);
			v_s3 <= force_gray ? CHROMA_ZERO : clamp_u8(vsum);
		end
	end

	// Stage 4: matrix products.
	logic signed [8:0]  ym, um, vm;
	logic signed [18:0] c_rv, c_gu, c_gv, c_bu;
	logic signed [27:0] yt_s4, rv_s4, gu_s4, gv_s4, bu_s4;
	logic vld_s4;

	always_comb begin
		ym = $signed({1'b0, y_s3}) - LUMA_BLACK;
		um = $signed({1'b0, u_s3}) - $signed({1'b0, CHROMA_ZERO});
		vm = $signed({1'b0, v_s3}) - $signed({1'b0, CHROMA_ZERO});
		if (matrix_select_q) begin
			c_rv = COEF_RV_709;
			c_gu = COEF_GU_709;
			c_gv = COEF_GV_709;
			c_bu = COEF_BU_709;
		end else begin
			c_rv = COEF_RV_601;
			c_gu = COEF_GU_601;
			c_gv = COEF_GV_601;
			c_bu = COEF_BU_601;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (adv) begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			yt_s4 <= 28'(ym) * 28'(COEF_Y);
			rv_s4 <= 28'(vm) * 28'(c_rv);
			gu_s4 <= 28'(um) * 28'(c_gu);
			gv_s4 <= 28'(vm) * 28'(c_gv);
			bu_s4 <= 28'(um) * 28'(c_bu);
		end
	end

	// Stage 5: sums, floor shift by 16 and clamp into the output register.
	logic signed [29:0] r_sum, g_sum, b_sum;
	rgb_pix_t rgb_s5;
	logic vld_s5;

	always_comb begin
		r_sum = (30'(yt_s4) + 30'(rv_s4)) >>> 16;
		g_sum = (30'(yt_s4) + 30'(gu_s4) + 30'(gv_s4)) >>> 16;
		b_sum = (30'(yt_s4) + 30'(bu_s4)) >>> 16;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else if (adv) begin
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rgb_s5.red_out   <= clamp_u8(r_sum);
			rgb_s5.green_out <= clamp_u8(g_sum);
			rgb_s5.blue_out  <= clamp_u8(b_sum);
		end
	end

	assign rgb_valid = vld_s5;
	assign rgb       = rgb_s5;

`ifndef ASSERT_OFF
	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && pix_ready |=> vld_s1)
		else $error("accepted pixel did not enter the first stage");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s3 && !adv |=> vld_s3 && $stable(y_s3))
		else $error("stalled stage lost its contents");

	a_gray_chroma: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s3 && force_gray |-> u_s3 == CHROMA_ZERO && v_s3 == CHROMA_ZERO)
		else $error("gray mode did not force chroma to zero");

	a_out_from_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rgb_valid) |-> $past(vld_s4))
		else $error("output valid without an item in the last stage");
`endif

endmodule

[tb/yuv_adjust_and_rgb_convert_top_tb.sv]
`timescale 1ns / 100ps

module yuv_adjust_and_rgb_convert_top_tb;
	import yuvrgb_pkg::*;

	typedef struct {
		logic [7:0] luma_scale;
		logic [7:0] luma_offset;
		logic       luma_invert;
		logic [7:0] u_scale;
		logic [7:0] v_scale;
		logic [7:0] chroma_offset;
		logic       chroma_invert;
		logic       matrix_select;
	} adjust_regs_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       pix_valid = 1'b0;
	logic       pix_ready;
	yuv_pix_t   pix = '0;
	logic       rgb_valid;
	logic       rgb_ready = 1'b0;
	rgb_pix_t   rgb;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [3:0] cfg_index = '0;
	logic [7:0] cfg_data = '0;

	adjust_regs_t shadow_regs;
	rgb_pix_t     rgb_expected_q[$];
	int           mismatch_count = 0;
	bit           idle_on = 1'b1;
	int           rx_hold_cycles = 0;

	yuv_adjust_and_rgb_convert_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_valid (pix_valid),
		.pix_ready (pix_ready),
		.pix       (pix),
		.rgb_valid (rgb_valid),
		.rgb_ready (rgb_ready),
		.rgb       (rgb),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		#2_000_000;
		$display("Test completed with failures");
		$finish;
	end

	function automatic logic [7:0] clamp_byte(longint v);
		logic [7:0] r;
		if (v < 0) begin
			r = 8'd0;
		end else if (v > 255) begin
			r = 8'd255;
		end else begin
			r = v[7:0];
		end
		return r;
	endfunction

	function automatic int gain_adjust(int sample, bit inv, int pivot, int gain);
		longint v;
		v = inv ? 255 - sample : sample;
		v = (v - pivot) * gain + pivot;
		return int'(clamp_byte(v));
	endfunction

	function automatic rgb_pix_t convert_pixel(yuv_pix_t p, adjust_regs_t c);
		bit       lg;
		bit       ug;
		bit       vg;
		int       y;
		int       u;
		int       v;
		longint   rv;
		longint   gu;
		longint   gv;
		longint   bu;
		longint   yt;
		longint   ut;
		longint   vt;
		rgb_pix_t o;
		lg = c.luma_scale != 0;
		ug = c.u_scale != 0;
		vg = c.v_scale != 0;
		// A single nonzero gain (luma, U or V) shows that plane as a gray image.
		if (lg && !ug && !vg) begin
			y = gain_adjust(p.luma_in, c.luma_invert, c.luma_offset, c.luma_scale);
			u = CHROMA_ZERO;
			v = CHROMA_ZERO;
		end else if (!lg && ug && !vg) begin
			y = gain_adjust(p.cb_in, c.chroma_invert, c.chroma_offset, c.u_scale);
			u = CHROMA_ZERO;
			v = CHROMA_ZERO;
		end else if (!lg && !ug && vg) begin
			y = gain_adjust(p.cr_in, c.chroma_invert, c.chroma_offset, c.v_scale);
			u = CHROMA_ZERO;
			v = CHROMA_ZERO;
		end else begin
			y = gain_adjust(p.luma_in, c.luma_invert, c.luma_offset, c.luma_scale);
			u = gain_adjust(p.cb_in, c.chroma_invert, c.chroma_offset, c.u_scale);
			v = gain_adjust(p.cr_in, c.chroma_invert, c.chroma_offset, c.v_scale);
		end
		if (c.matrix_select) begin
			rv = COEF_RV_709;
			gu = COEF_GU_709;
			gv = COEF_GV_709;
			bu = COEF_BU_709;
		end else begin
			rv = COEF_RV_601;
			gu = COEF_GU_601;
			gv = COEF_GV_601;
			bu = COEF_BU_601;
		end
		yt = (longint'(y) - longint'(LUMA_BLACK)) * longint'(COEF_Y);
		ut = longint'(u) - longint'(CHROMA_ZERO);
		vt = longint'(v) - longint'(CHROMA_ZERO);
		o.red_out   = clamp_byte((yt + vt * rv) >>> 16);
		o.green_out = clamp_byte((yt + ut * gu + vt * gv) >>> 16);
		o.blue_out  = clamp_byte((yt + ut * bu) >>> 16);
		return o;
	endfunction

	function automatic adjust_regs_t make_regs(logic [7:0] ls, logic [7:0] lo, logic li,
			logic [7:0] us, logic [7:0] vs, logic [7:0] co, logic ci, logic ms);
		adjust_regs_t s;
		s.luma_scale    = ls;
		s.luma_offset   = lo;
		s.luma_invert   = li;
		s.u_scale       = us;
		s.v_scale       = vs;
		s.chroma_offset = co;
		s.chroma_invert = ci;
		s.matrix_select = ms;
		return s;
	endfunction

	function automatic logic [7:0] pick_gain();
		logic [7:0] g;
		case ($urandom_range(0, 3))
			0: g = 8'd1;
			1: g = 8'd255;
			2: g = 8'($urandom_range(1, 4));
			default: g = 8'($urandom_range(1, 255));
		endcase
		return g;
	endfunction

	function automatic logic [7:0] pick_byte();
		logic [7:0] b;
		case ($urandom_range(0, 5))
			0: b = 8'd0;
			1: b = 8'd255;
			2: b = 8'd128;
			default: b = 8'($urandom);
		endcase
		return b;
	endfunction

	function automatic adjust_regs_t random_regs();
		adjust_regs_t s;
		s = make_regs(8'd0, pick_byte(), 1'($urandom), 8'd0, 8'd0, pick_byte(),
			1'($urandom), 1'($urandom));
		case ($urandom_range(0, 5))
			0: s.luma_scale = pick_gain();
			1: s.u_scale = pick_gain();
			2: s.v_scale = pick_gain();
			3: ;
			default: begin
				s.luma_scale = $urandom_range(0, 1) ? pick_gain() : 8'd0;
				s.u_scale    = $urandom_range(0, 1) ? pick_gain() : 8'd0;
				s.v_scale    = $urandom_range(0, 1) ? pick_gain() : 8'd0;
			end
		endcase
		return s;
	endfunction

	function automatic yuv_pix_t random_pixel();
		yuv_pix_t p;
		p = yuv_pix_t'(24'($urandom));
		if ($urandom_range(0, 7) == 0) begin
			p.luma_in = pick_byte();
			p.cb_in   = pick_byte();
			p.cr_in   = pick_byte();
		end
		return p;
	endfunction

	task automatic send_pixel(yuv_pix_t p);
		int gap;
		gap = idle_on ? $urandom_range(0, 5) : 0;
		if (gap > 0) begin
			pix_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pix_valid <= 1'b1;
		pix <= p;
		do @(posedge clk); while (pix_ready !== 1'b1);
		rgb_expected_q.push_back(convert_pixel(p, shadow_regs));
	endtask

	task automatic drain_pipeline();
		pix_valid <= 1'b0;
		while (rgb_expected_q.size() != 0) @(posedge clk);
	endtask

	// Leaves cfg_valid high so that writes can go back to back.
	task automatic cfg_write(logic [3:0] idx, logic [7:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		case (idx)
			REG_LUMA_SCALE:    shadow_regs.luma_scale    = data;
			REG_LUMA_OFFSET:   shadow_regs.luma_offset   = data;
			REG_LUMA_INVERT:   shadow_regs.luma_invert   = data[0];
			REG_U_SCALE:       shadow_regs.u_scale       = data;
			REG_V_SCALE:       shadow_regs.v_scale       = data;
			REG_CHROMA_OFFSET: shadow_regs.chroma_offset = data;
			REG_CHROMA_INVERT: shadow_regs.chroma_invert = data[0];
			REG_MATRIX_SELECT: shadow_regs.matrix_select = data[0];
			default: ;
		endcase
	endtask

	// The upper bits of the one-bit registers carry noise that must be dropped.
	task automatic apply_regs(adjust_regs_t s);
		drain_pipeline();
		cfg_write(REG_LUMA_SCALE, s.luma_scale);
		cfg_write(REG_LUMA_OFFSET, s.luma_offset);
		cfg_write(REG_LUMA_INVERT, {7'($urandom), s.luma_invert});
		cfg_write(REG_U_SCALE, s.u_scale);
		cfg_write(REG_V_SCALE, s.v_scale);
		cfg_write(REG_CHROMA_OFFSET, s.chroma_offset);
		cfg_write(REG_CHROMA_INVERT, {7'($urandom), s.chroma_invert});
		cfg_write(REG_MATRIX_SELECT, {7'($urandom), s.matrix_select});
		cfg_valid <= 1'b0;
	endtask

	task automatic test_reset_defaults();
		send_pixel('{8'd0, 8'd0, 8'd0});
		send_pixel('{8'd255, 8'd255, 8'd255});
		send_pixel('{8'd16, 8'd128, 8'd128});
		send_pixel('{8'd235, 8'd128, 8'd128});
		send_pixel('{8'd81, 8'd90, 8'd240});
	endtask

	task automatic test_display_modes();
		adjust_regs_t modes[5];
		modes[0] = make_regs(8'd255, 8'd0, 1'b1, 8'd0, 8'd0, 8'd255, 1'b0, 1'b1);
		modes[1] = make_regs(8'd0, 8'd255, 1'b0, 8'd255, 8'd0, 8'd0, 1'b1, 1'b0);
		modes[2] = make_regs(8'd0, 8'd0, 1'b0, 8'd0, 8'd2, 8'd128, 1'b0, 1'b1);
		modes[3] = make_regs(8'd0, 8'd0, 1'b1, 8'd0, 8'd0, 8'd0, 1'b1, 1'b0);
		modes[4] = make_regs(8'd255, 8'd255, 1'b1, 8'd255, 8'd255, 8'd255, 1'b1, 1'b1);
		foreach (modes[i]) begin
			apply_regs(modes[i]);
			send_pixel('{8'd0, 8'd255, 8'd0});
			send_pixel('{8'd255, 8'd0, 8'd255});
			send_pixel('{8'd128, 8'd128, 8'd128});
		end
	endtask

	// Indexes past the register list must leave every register as it was.
	task automatic test_unused_index();
		drain_pipeline();
		for (int i = 8; i < 16; i++) begin
			cfg_write(4'(i), 8'($urandom));
		end
		cfg_valid <= 1'b0;
		send_pixel('{8'd200, 8'd30, 8'd220});
		send_pixel('{8'd40, 8'd250, 8'd10});
	endtask

	task automatic test_backpressure();
		apply_regs(make_regs(8'd2, 8'd100, 1'b0, 8'd3, 8'd1, 8'd128, 1'b0, 1'b0));
		idle_on = 1'b0;
		rx_hold_cycles = 60;
		repeat (40) send_pixel(random_pixel());
		drain_pipeline();
		idle_on = 1'b1;
	endtask

	task automatic test_random_pixels();
		for (int phase = 0; phase < 10; phase++) begin
			apply_regs(random_regs());
			idle_on = (phase % 3) != 2;
			repeat (85) send_pixel(random_pixel());
		end
		drain_pipeline();
		idle_on = 1'b1;
	endtask

	initial begin
		int       gap;
		int       hold;
		rgb_pix_t got;
		rgb_pix_t want;
		wait (arst_n === 1'b1);
		forever begin
			if (rx_hold_cycles > 0) begin
				hold = rx_hold_cycles;
				rx_hold_cycles = 0;
				rgb_ready <= 1'b0;
				repeat (hold) @(posedge clk);
			end
			gap = idle_on ? $urandom_range(0, 5) : 0;
			if (gap > 0) begin
				rgb_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			rgb_ready <= 1'b1;
			do @(posedge clk); while (rgb_valid !== 1'b1);
			got = rgb;
			if (rgb_expected_q.size() == 0) begin
				$error("rgb transfer with no pixel outstanding: %h", got);
				mismatch_count++;
			end else begin
				want = rgb_expected_q.pop_front();
				if (got.red_out !== want.red_out) begin
					$error("red_out: expected %0d, actual %0d", want.red_out, got.red_out);
					mismatch_count++;
				end
				if (got.green_out !== want.green_out) begin
					$error("green_out: expected %0d, actual %0d", want.green_out,
						got.green_out);
					mismatch_count++;
				end
				if (got.blue_out !== want.blue_out) begin
					$error("blue_out: expected %0d, actual %0d", want.blue_out, got.blue_out);
					mismatch_count++;
				end
			end
		end
	end

	initial begin
		shadow_regs = make_regs(RST_LUMA_SCALE, RST_LUMA_OFFSET, 1'b0, RST_U_SCALE,
			RST_V_SCALE, RST_CHROMA_OFFSET, 1'b0, 1'b0);
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_display_modes();
		test_unused_index();
		test_backpressure();
		test_random_pixels();
		drain_pipeline();
		repeat (10) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

[sim.f]
src/yuvrgb_pkg.sv
src/yuv_adjust_and_rgb_convert_top.sv
tb/yuv_adjust_and_rgb_convert_top_tb.sv
